[design/lcs_pkg.sv]
// lcs_pkg: shared constants, types and helpers for the LRU cache set.
// No dependencies; imported by lcs_ctrl, lcs_datapath and lru_cache_set_core.
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int unsigned WAYS     = 8;
  localparam int unsigned TAG_BITS = 32;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W    = $clog2(WAYS + 1);
  localparam int unsigned CFG_W    = 4;

  localparam logic [CFG_W-1:0] WAYS_RESET = CFG_W'(8);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_tag;  // capture the incoming access tag
    logic commit;    // look up, update the stack and load the result register
  } lcs_cmd_t;

  // way limit in effect: register clamped to 1..WAYS
  function automatic logic [CNT_W-1:0] lcs_limit(input logic [CFG_W-1:0] ways);
    logic [CNT_W-1:0] lim;
    if (ways == '0) begin
      lim = CNT_W'(1);
    end else if ({1'b0, ways} > (CFG_W + 1)'(WAYS)) begin
      lim = CNT_W'(WAYS);
    end else begin
      lim = CNT_W'(ways);
    end
    return lim;
  endfunction

endpackage

[design/lcs_ctrl.sv]
// lcs_ctrl: sequencer for the LRU cache set; drives the handshakes and datapath commands.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lcs_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    cmd_o.load_tag = 1'b0;
    cmd_o.commit   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load_tag = 1'b1;
          state_d        = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold until the result register can take the new result
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_LOOKUP))
    else $error("accepted item not looked up");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");
`endif

endmodule

[design/lcs_datapath.sv]
// lcs_datapath: recency stack, fill count, way-limit register, tag compare and result register.
// Depends on lcs_pkg; commanded by lcs_ctrl.
`timescale 1ns / 1ps

module lcs_datapath
  import lcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcs_cmd_t            cmd_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [TAG_BITS-1:0] access_tag_i,
  output logic                hit_o,
  output logic                evicted_o,
  output logic [31:0]         evicted_tag_o
);

  logic [TAG_BITS-1:0] stack_q [WAYS];
  logic [TAG_BITS-1:0] stack_d [WAYS];
  logic [TAG_BITS-1:0] tag_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CFG_W-1:0]    ways_q;
  logic [CNT_W-1:0]    limit;
  logic [WAYS-1:0]     match;
  logic                hit;
  logic                full;
  logic                evict;
  logic [WAY_W-1:0]    found;
  logic [WAY_W-1:0]    pos;
  logic [WAY_W-1:0]    last_idx;
  logic [TAG_BITS-1:0] ev_tag;
  logic                hit_q;
  logic                evicted_q;
  logic [31:0]         evicted_tag_q;

  assign limit    = lcs_limit(ways_q);
  assign full     = (count_q >= limit);
  assign last_idx = WAY_W'(count_q - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (stack_q[i] == tag_q);
    end
    found = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = WAY_W'(i);
      end
    end
  end

  assign hit    = |match;
  assign evict  = ~hit & full;
  assign ev_tag = stack_q[last_idx];

  // entry that the shift overwrites: the hit way, the LRU way, or the first free way
  always_comb begin
    if (hit) begin
      pos = found;
    end else if (full) begin
      pos = last_idx;
    end else begin
      pos = WAY_W'(count_q);
    end
  end

  always_comb begin
    stack_d = stack_q;
    count_d = count_q;
    if (cmd_i.commit) begin
      stack_d[0] = tag_q;
      for (int i = 1; i < WAYS; i++) begin
        if (WAY_W'(i) <= pos) begin
          stack_d[i] = stack_q[i-1];
        end
      end
      if (!hit && !full) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ways_q  <= WAYS_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        ways_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stack_q <= stack_d;
    if (cmd_i.load_tag) begin
      tag_q <= access_tag_i;
    end
    if (cmd_i.commit) begin
      hit_q         <= hit;
      evicted_q     <= evict;
      evicted_tag_q <= evict ? 32'(ev_tag) : 32'd0;
    end
  end

  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign evicted_tag_o = evicted_tag_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WAYS))
    else $error("fill count above way count");

  a_evict_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && evict) |=> (count_q == $past(count_q)))
    else $error("eviction changed the fill count");

  a_hit_not_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(hit && evict))
    else $error("hit and eviction together");

  a_front_is_last_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (stack_q[0] == $past(tag_q)))
    else $error("accessed tag not at the front");
`endif

endmodule

[design/lru_cache_set_core.sv]
// lru_cache_set_core: one set of a set-associative cache with true LRU replacement.
// Depends on lcs_pkg, lcs_ctrl and lcs_datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------
//   in       | in_valid_i / in_ready_o  | access_tag_i
//   out      | out_valid_o / out_ready_i| hit_o, evicted_o, evicted_tag_o
//   config   | cfg_we_i (no wait)       | cfg_wdata_i (ways in use)
//
// Each item first captures the tag, then compares all ways in parallel, shifts the
// recency stack and loads the result register.
// The next item is taken while the previous result still waits in the output register.
// A stalled output holds the lookup cycle until the result register frees.
// Reset clears the fill count and sets ways in use to 8; stack entries need no clearing.
`timescale 1ns / 1ps

module lru_cache_set_core
  import lcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         access_tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic                evicted_o,
  output logic [31:0]         evicted_tag_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  lcs_cmd_t cmd;

  lcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  lcs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .access_tag_i (access_tag_i[TAG_BITS-1:0]),
    .hit_o        (hit_o),
    .evicted_o    (evicted_o),
    .evicted_tag_o(evicted_tag_o)
  );

endmodule
